// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/rmva_pkg.sv =====
package rmva_pkg;

  localparam int DEF_SAMPLE_BITS = 32;
  localparam int DEF_FRAC_BITS   = 16;
  localparam int IN_BITS         = 32;
  localparam int COUNT_BITS      = 32;
  localparam int MEAN_BITS       = 48;
  localparam int SUM_BITS        = 64;
  localparam int SE_BITS         = 48;
  localparam int OP_BITS         = 64;
  localparam int OUT_BITS        = COUNT_BITS + MEAN_BITS + SUM_BITS + SE_BITS;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MDIV,
    S_MDIV_W,
    S_PMUL,
    S_PMUL_W,
    S_DMUL,
    S_DMUL_W,
    S_QDIV,
    S_QDIV_W,
    S_ROOT,
    S_ROOT_W,
    S_FIN
  } state_t;

  // operand set for the shared divider and multiplier
  typedef enum logic {
    SEL_MEAN,
    SEL_SE
  } unit_sel_t;

  typedef struct packed {
    logic      load_in;
    logic      div_start;
    logic      mul_start;
    logic      sqrt_start;
    unit_sel_t sel;
    logic      upd_mean;
    logic      upd_sum;
    logic      ld_den;
    logic      ld_q;
    logic      load_out;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic mul_done;
    logic sqrt_done;
    logic ge2;
  } sts_t;

endpackage

// ===== rtl/rmva_div.sv =====
module rmva_div #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic [W-1:0] quo,
  output logic         done
);
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  rem_r, rem_nxt, quo_r, quo_nxt, den_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          done_r, done_nxt;
  logic [W:0]    t, diff;
  logic          ge;

  // restoring division, one quotient bit a cycle
  always_comb begin
    t        = {rem_r, quo_r[W-1]};
    diff     = t - {1'b0, den_r};
    ge       = (t >= {1'b0, den_r});
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = '0;
      quo_nxt = num;
      cnt_nxt = CW'(W);
    end else if (cnt_r != '0) begin
      rem_nxt  = ge ? diff[W-1:0] : t[W-1:0];
      quo_nxt  = {quo_r[W-2:0], ge};
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) den_r <= den;
  end

  assign quo  = quo_r;
  assign done = done_r;
endmodule

// ===== rtl/rmva_mul.sv =====
module rmva_mul #(
  parameter int W = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [W-1:0]   a,
  input  logic [W-1:0]   b,
  output logic [2*W-1:0] prod,
  output logic           done
);
  localparam int CW = $clog2(W + 1);

  logic [2*W-1:0] prod_r, prod_nxt;
  logic [W-1:0]   a_r;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           done_r, done_nxt;
  logic [W:0]     s;

  // shift-add, one multiplier bit a cycle; multiplier sits in the low half
  always_comb begin
    s        = {1'b0, prod_r[2*W-1:W]} + (prod_r[0] ? {1'b0, a_r} : '0);
    prod_nxt = prod_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      prod_nxt = {{W{1'b0}}, b};
      cnt_nxt  = CW'(W);
    end else if (cnt_r != '0) begin
      prod_nxt = {s, prod_r[W-1:1]};
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    prod_r <= prod_nxt;
    if (start) a_r <= a;
  end

  assign prod = prod_r;
  assign done = done_r;
endmodule

// ===== rtl/rmva_sqrt.sv =====
module rmva_sqrt #(
  parameter int RW = 80
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [RW-1:0]   rad,
  output logic [RW/2-1:0] root,
  output logic            done
);
  localparam int HW = RW / 2;
  localparam int CW = $clog2(HW + 1);

  logic [RW-1:0] rad_r, rad_nxt;
  logic [HW-1:0] root_r, root_nxt;
  logic [HW+1:0] rem_r, rem_nxt;
  logic [HW+3:0] r2, trial, diff;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          done_r, done_nxt;
  logic          ge;

  // digit-by-digit root, two radicand bits a cycle
  always_comb begin
    r2       = {rem_r, rad_r[RW-1 -: 2]};
    trial    = {2'b00, root_r, 2'b01};
    diff     = r2 - trial;
    ge       = (r2 >= trial);
    rad_nxt  = rad_r;
    root_nxt = root_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      rad_nxt  = rad;
      root_nxt = '0;
      rem_nxt  = '0;
      cnt_nxt  = CW'(HW);
    end else if (cnt_r != '0) begin
      rad_nxt  = {rad_r[RW-3:0], 2'b00};
      root_nxt = {root_r[HW-2:0], ge};
      rem_nxt  = ge ? diff[HW+1:0] : r2[HW+1:0];
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    rad_r  <= rad_nxt;
    root_r <= root_nxt;
    rem_r  <= rem_nxt;
  end

  assign root = root_r;
  assign done = done_r;
endmodule

// ===== rtl/rmva_dp.sv =====
module rmva_dp #(
  parameter int SAMPLE_BITS = rmva_pkg::DEF_SAMPLE_BITS,
  parameter int FRAC_BITS   = rmva_pkg::DEF_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rmva_pkg::cmd_t                cmd,
  output rmva_pkg::sts_t                sts,
  input  logic [rmva_pkg::IN_BITS-1:0]  in_tdata,
  output logic [rmva_pkg::OUT_BITS-1:0] out_tdata,
  output logic                          out_tuser
);
  import rmva_pkg::*;

  localparam int XW = SAMPLE_BITS + FRAC_BITS;
  localparam int DW = (XW > MEAN_BITS) ? XW : MEAN_BITS;
  localparam int RW = SUM_BITS + FRAC_BITS + (FRAC_BITS % 2);
  localparam int HW = RW / 2;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [MEAN_BITS-1:0]  MEAN_MAX  = '1;

  logic [COUNT_BITS-1:0] count_r;
  logic [MEAN_BITS-1:0]  mean_r;
  logic [SUM_BITS-1:0]   sq_r;
  logic [DW-1:0]         x_r, d_r;
  logic                  ge_r;
  logic [OP_BITS-1:0]    den_r, q_r;
  logic [OUT_BITS-1:0]   out_data_r;
  logic                  out_user_r;

  logic [DW-1:0]        m_ext, d, e, qd;
  logic [DW:0]          nm_add;
  logic [MEAN_BITS-1:0] nm;
  logic [OP_BITS-1:0]   div_num, div_den, div_quo, mul_a, mul_b;
  logic [2*OP_BITS-1:0] prod;
  logic [SUM_BITS-1:0]  inc;
  logic [SUM_BITS:0]    sum_w;
  logic [HW-1:0]        root;
  logic [SE_BITS-1:0]   se;
  logic                 ge_now, ge2;
  logic                 div_done, mul_done, sqrt_done;

  always_comb begin
    m_ext   = DW'(mean_r);
    ge_now  = (x_r >= m_ext);
    d       = ge_now ? (x_r - m_ext) : (m_ext - x_r);
    e       = ge_r ? (x_r - m_ext) : (m_ext - x_r);
    qd      = div_quo[DW-1:0];
    nm_add  = {1'b0, m_ext} + {1'b0, qd};
    if (ge_r) begin
      nm = (nm_add > (DW+1)'(MEAN_MAX)) ? MEAN_MAX : nm_add[MEAN_BITS-1:0];
    end else begin
      nm = mean_r - qd[MEAN_BITS-1:0];
    end
    div_num = (cmd.sel == SEL_MEAN) ? OP_BITS'(d) : sq_r;
    div_den = (cmd.sel == SEL_MEAN) ? OP_BITS'(count_r) : den_r;
    mul_a   = (cmd.sel == SEL_MEAN) ? OP_BITS'(d_r) : OP_BITS'(count_r - 1'b1);
    mul_b   = (cmd.sel == SEL_MEAN) ? OP_BITS'(e) : OP_BITS'(count_r);
    // increment saturates once the product reaches 2^(64+F)
    inc     = (prod[2*OP_BITS-1:SUM_BITS+FRAC_BITS] != '0) ? '1
              : prod[SUM_BITS+FRAC_BITS-1:FRAC_BITS];
    sum_w   = {1'b0, sq_r} + {1'b0, inc};
    se      = (HW > SE_BITS && (root >> SE_BITS) != '0) ? '1 : SE_BITS'(root);
    ge2     = (count_r >= COUNT_BITS'(2));
  end

  rmva_div #(.W(OP_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .num(div_num), .den(div_den), .quo(div_quo), .done(div_done)
  );

  rmva_mul #(.W(OP_BITS)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(cmd.mul_start),
    .a(mul_a), .b(mul_b), .prod(prod), .done(mul_done)
  );

  rmva_sqrt #(.RW(RW)) u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(cmd.sqrt_start),
    .rad(RW'({q_r, {FRAC_BITS{1'b0}}})), .root(root), .done(sqrt_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      mean_r  <= '0;
      sq_r    <= '0;
    end else begin
      if (cmd.load_in) count_r <= (count_r == COUNT_MAX) ? COUNT_MAX : count_r + 1'b1;
      if (cmd.upd_mean) mean_r <= nm;
      if (cmd.upd_sum) sq_r <= sum_w[SUM_BITS] ? '1 : sum_w[SUM_BITS-1:0];
    end
    if (cmd.load_in) x_r <= DW'({in_tdata[SAMPLE_BITS-1:0], {FRAC_BITS{1'b0}}});
    if (cmd.div_start && cmd.sel == SEL_MEAN) begin
      d_r  <= d;
      ge_r <= ge_now;
    end
    if (cmd.ld_den) den_r <= prod[OP_BITS-1:0];
    if (cmd.ld_q) q_r <= div_quo;
    if (cmd.load_out) begin
      out_data_r <= {(ge2 ? se : '0), sq_r, mean_r, count_r};
      out_user_r <= ge2;
    end
  end

  assign sts       = '{div_done: div_done, mul_done: mul_done,
                       sqrt_done: sqrt_done, ge2: ge2};
  assign out_tdata = out_data_r;
  assign out_tuser = out_user_r;
endmodule

// ===== rtl/rmva_ctrl.sv =====
`include "assert_macros.svh"

module rmva_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  output rmva_pkg::cmd_t cmd,
  input  rmva_pkg::sts_t sts
);
  import rmva_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_tvalid) state_nxt = S_MDIV;
      S_MDIV:   state_nxt = S_MDIV_W;
      S_MDIV_W: if (sts.div_done) state_nxt = S_PMUL;
      S_PMUL:   state_nxt = S_PMUL_W;
      S_PMUL_W: if (sts.mul_done) state_nxt = sts.ge2 ? S_DMUL : S_FIN;
      S_DMUL:   state_nxt = S_DMUL_W;
      S_DMUL_W: if (sts.mul_done) state_nxt = S_QDIV;
      S_QDIV:   state_nxt = S_QDIV_W;
      S_QDIV_W: if (sts.div_done) state_nxt = S_ROOT;
      S_ROOT:   state_nxt = S_ROOT_W;
      S_ROOT_W: if (sts.sqrt_done) state_nxt = S_FIN;
      S_FIN:    if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.sel   = SEL_MEAN;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready   = 1'b1;
        cmd.load_in = in_tvalid;
      end
      S_MDIV:   cmd.div_start = 1'b1;
      S_MDIV_W: cmd.upd_mean  = sts.div_done;
      S_PMUL:   cmd.mul_start = 1'b1;
      S_PMUL_W: cmd.upd_sum   = sts.mul_done;
      S_DMUL: begin
        cmd.sel       = SEL_SE;
        cmd.mul_start = 1'b1;
      end
      S_DMUL_W: begin
        cmd.sel    = SEL_SE;
        cmd.ld_den = sts.mul_done;
      end
      S_QDIV: begin
        cmd.sel       = SEL_SE;
        cmd.div_start = 1'b1;
      end
      S_QDIV_W: begin
        cmd.sel  = SEL_SE;
        cmd.ld_q = sts.div_done;
      end
      S_ROOT:   cmd.sqrt_start = 1'b1;
      S_ROOT_W: cmd.sel = SEL_SE;
      S_FIN:    cmd.load_out = out_free;
      default:  cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  `ASSERT_CLK(a_div_done_wait, !sts.div_done || state_r == S_MDIV_W || state_r == S_QDIV_W, "divider done outside a wait state")
  `ASSERT_CLK(a_mul_done_wait, !sts.mul_done || state_r == S_PMUL_W || state_r == S_DMUL_W, "multiplier done outside a wait state")
  `ASSERT_CLK(a_sqrt_done_wait, !sts.sqrt_done || state_r == S_ROOT_W, "root done outside its wait state")
  `ASSERT_NEXT(a_load_out_valid, cmd.load_out, out_valid_r && state_r == S_IDLE, "result not presented after load")
endmodule

// ===== rtl/running_mean_variance_accumulator.sv =====
// Running mean / variance accumulator (Welford update), unsigned fixed point.
// Input channel in_*: one beat carries one sample in in_tdata[SAMPLE_BITS-1:0].
// Result channel out_*: one beat per accepted sample with the updated count,
// mean, sum of squared deviations and standard error; out_tuser is the
// standard-error valid flag (count of two or more).
// One sample is processed at a time. The work runs through a shared 64-bit
// restoring divider, a 64-bit shift-add multiplier and a digit-by-digit root
// of (64+FRAC_BITS)/2 steps, rounded up; the very first sample skips the error
// term.
// in_tready is high only while the block is idle, and it may take the next
// sample while a finished result still waits on out_tready. A stalled
// receiver holds the result steady; the next result waits until it is taken.
// Reset (rst_n low, synchronous) clears count, mean, sum and any pending beat.
module running_mean_variance_accumulator #(
  parameter int SAMPLE_BITS = rmva_pkg::DEF_SAMPLE_BITS,
  parameter int FRAC_BITS   = rmva_pkg::DEF_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // sample[31:0]
  input  logic [rmva_pkg::IN_BITS-1:0]  in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // count[31:0], running_mean[79:32], sum_sq[143:80], std_error[191:144]
  output logic [rmva_pkg::OUT_BITS-1:0] out_tdata,
  // std_error_valid[0]
  output logic                          out_tuser
);
  import rmva_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: a start state and a wait state for each unit pass
  rmva_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cmd(cmd), .sts(sts)
  );

  // accumulators, shared arithmetic units and the result register
  rmva_dp #(.SAMPLE_BITS(SAMPLE_BITS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_tdata(in_tdata), .out_tdata(out_tdata), .out_tuser(out_tuser)
  );
endmodule
